// File: rtl/pmc_pkg.sv
package pmc_pkg;

  localparam int ByteW   = 8;
  localparam int ShiftW  = 3;
  localparam int ButtonW = 3;
  localparam int CellW   = 16;
  localparam int CfgAddrW = 2;

  localparam int StatusFullBit = 0;
  localparam int StatusAuxBit  = 5;
  localparam int HeaderSyncBit = 3;

  localparam logic [ByteW-1:0]  ResetColumns = 8'd80;
  localparam logic [ByteW-1:0]  ResetRows    = 8'd25;
  localparam logic [ShiftW-1:0] ResetShift   = 3'd3;
  localparam logic [ByteW-1:0]  ResetPosX    = 8'd40;
  localparam logic [ByteW-1:0]  ResetPosY    = 8'd12;

  typedef enum logic [CfgAddrW-1:0] {
    REG_GRID_COLUMNS = 2'd0,
    REG_GRID_ROWS    = 2'd1,
    REG_MOTION_SHIFT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ByteW-1:0]  grid_columns;
    logic [ByteW-1:0]  grid_rows;
    logic [ShiftW-1:0] motion_shift;
  } cfg_t;

  // one completed packet, handed from the front to the back
  typedef struct packed {
    logic [ButtonW-1:0] buttons;
    logic [ByteW-1:0]   dx_raw;
    logic [ByteW-1:0]   dy_raw;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [ByteW-1:0]   cursor_x;
    logic [ByteW-1:0]   cursor_y;
    logic [ButtonW-1:0] button_bits;
    logic               moved;
    logic [CellW-1:0]   old_cell;
    logic [CellW-1:0]   new_cell;
  } result_t;

endpackage

// File: rtl/pmc_in_if.sv
interface pmc_in_if;
  logic                        valid;
  logic                        ready;
  logic [pmc_pkg::ByteW-1:0]   ctrl_status;
  logic [pmc_pkg::ByteW-1:0]   rx_byte;

  modport source (output valid, ctrl_status, rx_byte, input ready);
  modport sink   (input valid, ctrl_status, rx_byte, output ready);
endinterface

// File: rtl/pmc_out_if.sv
interface pmc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pmc_pkg::ByteW-1:0]     cursor_x;
  logic [pmc_pkg::ByteW-1:0]     cursor_y;
  logic [pmc_pkg::ButtonW-1:0]   button_bits;
  logic                          moved;
  logic [pmc_pkg::CellW-1:0]     old_cell;
  logic [pmc_pkg::CellW-1:0]     new_cell;

  modport source (output valid, cursor_x, cursor_y, button_bits, moved, old_cell, new_cell,
                  input ready);
  modport sink   (input valid, cursor_x, cursor_y, button_bits, moved, old_cell, new_cell,
                  output ready);
endinterface

// File: rtl/pmc_cfg_if.sv
interface pmc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pmc_pkg::CfgAddrW-1:0]   addr;
  logic [pmc_pkg::ByteW-1:0]      data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/pmc_front.sv
module pmc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic [pmc_pkg::ByteW-1:0]   ctrl_status,
  input  logic [pmc_pkg::ByteW-1:0]   rx_byte,
  output logic                        push,
  output pmc_pkg::pkt_t               push_pkt
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DX     = 3'b010,
    PH_DY     = 3'b100
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [pmc_pkg::ByteW-1:0]   header_r, header_nxt;
  logic [pmc_pkg::ByteW-1:0]   dx_r, dx_nxt;
  logic                        take;

  assign take = in_fire && ctrl_status[pmc_pkg::StatusFullBit]
                && ctrl_status[pmc_pkg::StatusAuxBit];

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    dx_nxt     = dx_r;
    push       = 1'b0;
    if (take) begin
      unique case (phase_r)
        PH_HEADER: begin
          // drop bytes until one carries the sync bit
          if (rx_byte[pmc_pkg::HeaderSyncBit]) begin
            header_nxt = rx_byte;
            phase_nxt  = PH_DX;
          end
        end
        PH_DX: begin
          dx_nxt    = rx_byte;
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          push      = 1'b1;
          phase_nxt = PH_HEADER;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  assign push_pkt.buttons = header_r[pmc_pkg::ButtonW-1:0];
  assign push_pkt.dx_raw  = dx_r;
  assign push_pkt.dy_raw  = rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      header_r <= '0;
      dx_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      dx_r     <= dx_nxt;
    end
  end

endmodule

// File: rtl/pmc_queue.sv
module pmc_queue #(
  parameter int Depth = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pmc_pkg::pkt_t        push_pkt,
  input  logic                 pop,
  output pmc_pkg::pkt_t        head_pkt,
  output pmc_pkg::q_status_t   status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pmc_pkg::pkt_t    mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  assign status.full  = (cnt_r == CntW'(Depth));
  assign status.empty = (cnt_r == '0);
  assign head_pkt     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CntW'(1);
      2'b01:   cnt_nxt = cnt_r - CntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/pmc_back.sv
module pmc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pmc_pkg::cfg_t         cfg,
  input  pmc_pkg::q_status_t    q_status,
  input  pmc_pkg::pkt_t         head_pkt,
  output logic                  pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pmc_pkg::result_t      res
);

  typedef struct packed {
    logic [pmc_pkg::ByteW-1:0]   old_x;
    logic [pmc_pkg::ByteW-1:0]   old_y;
    logic [pmc_pkg::ByteW-1:0]   new_x;
    logic [pmc_pkg::ByteW-1:0]   new_y;
    logic [pmc_pkg::ButtonW-1:0] buttons;
  } move_t;

  function automatic logic [8:0] scale_motion(input logic [7:0] raw, input logic [2:0] sh);
    logic [7:0] mag;
    logic [7:0] shv;
    mag = raw[7] ? (~raw + 8'd1) : raw;
    shv = mag >> sh;
    return raw[7] ? (9'd0 - {1'b0, shv}) : {1'b0, shv};
  endfunction

  function automatic logic [7:0] clamp_axis(input logic [9:0] v, input logic [7:0] top);
    logic [7:0] r;
    if (v[9]) begin
      r = '0;
    end else if (v[8:0] > {1'b0, top}) begin
      r = top;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  logic [pmc_pkg::ByteW-1:0] pos_x_r, pos_x_nxt;
  logic [pmc_pkg::ByteW-1:0] pos_y_r, pos_y_nxt;
  logic [pmc_pkg::ButtonW-1:0] buttons_r;
  logic                      s1_valid_r;
  move_t                     s1_r, s1_nxt;
  logic                      out_valid_r;
  pmc_pkg::result_t          out_r, out_nxt;
  logic                      out_adv;
  logic                      s1_adv;
  logic [8:0]                dx, dy;
  logic [9:0]                sum_x, sum_y;
  logic [pmc_pkg::ByteW-1:0] top_x, top_y;
  logic [pmc_pkg::CellW-1:0] prod_old, prod_new;

  assign out_adv = !out_valid_r || res_ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign pop     = s1_adv && !q_status.empty;

  // stage 1: scale, move and clamp against the live position
  always_comb begin
    dx    = scale_motion(head_pkt.dx_raw, cfg.motion_shift);
    dy    = scale_motion(head_pkt.dy_raw, cfg.motion_shift);
    sum_x = {2'b00, pos_x_r} + {dx[8], dx};
    sum_y = {2'b00, pos_y_r} - {dy[8], dy};
    top_x = (cfg.grid_columns == '0) ? '0 : cfg.grid_columns - 8'd1;
    top_y = (cfg.grid_rows == '0) ? '0 : cfg.grid_rows - 8'd1;
    s1_nxt.old_x   = pos_x_r;
    s1_nxt.old_y   = pos_y_r;
    s1_nxt.new_x   = clamp_axis(sum_x, top_x);
    s1_nxt.new_y   = clamp_axis(sum_y, top_y);
    s1_nxt.buttons = head_pkt.buttons;
    pos_x_nxt = pop ? s1_nxt.new_x : pos_x_r;
    pos_y_nxt = pop ? s1_nxt.new_y : pos_y_r;
  end

  // stage 2: cell indices
  always_comb begin
    prod_old = {8'd0, s1_r.old_y} * {8'd0, cfg.grid_columns};
    prod_new = {8'd0, s1_r.new_y} * {8'd0, cfg.grid_columns};
    out_nxt.cursor_x    = s1_r.new_x;
    out_nxt.cursor_y    = s1_r.new_y;
    out_nxt.button_bits = s1_r.buttons;
    out_nxt.moved       = (s1_r.old_x != s1_r.new_x) || (s1_r.old_y != s1_r.new_y);
    out_nxt.old_cell    = prod_old + {8'd0, s1_r.old_x};
    out_nxt.new_cell    = prod_new + {8'd0, s1_r.new_x};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r <= s1_nxt;
    end
    if (s1_valid_r && out_adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= pmc_pkg::ResetPosX;
      pos_y_r     <= pmc_pkg::ResetPosY;
      buttons_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      if (pop) begin
        buttons_r <= head_pkt.buttons;
      end
      if (s1_adv) begin
        s1_valid_r <= pop;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  assign res_valid = out_valid_r;
  always_comb begin
    res = out_r;
    // latched buttons track the newest packet; the result carries its own copy
    if (buttons_r != out_r.button_bits && !out_valid_r) begin
      res.button_bits = out_r.button_bits;
    end
  end

endmodule

// File: rtl/ps2_mouse_packet_cursor_top.sv
// PS/2 mouse packet decoder driving a text-grid cursor. One controller status / data byte
// pair is taken per transfer, every clock cycle; bytes whose status lacks output-full and
// auxiliary-data are dropped. The front assembles header, X and Y bytes into packets
// (a header must have bit 3 set) and pushes each completed packet into a QueueDepth-entry
// queue. The back pops one packet per cycle unless the result port stalls, scales, moves
// and clamps the position in one register stage and forms the two cell indices
// (row * grid_columns + column) in a second, so a result passes the queue and both
// stages before it is offered, and waits longer while the result port stalls.
// Input stalls only when the queue is full, which takes a stalled result port. Write the
// grid and shift registers only while no packet is in flight; no clearing pass after reset.
module ps2_mouse_packet_cursor_top #(
  parameter int QueueDepth = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  pmc_in_if.sink     in_ch,
  pmc_out_if.source  out_ch,
  pmc_cfg_if.sink    cfg_ch
);

  pmc_pkg::cfg_t       cfg_r;
  pmc_pkg::pkt_t       push_pkt;
  pmc_pkg::pkt_t       head_pkt;
  pmc_pkg::q_status_t  q_status;
  pmc_pkg::result_t    res;
  logic                push;
  logic                pop;
  logic                in_fire;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_status.full;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_columns <= pmc_pkg::ResetColumns;
      cfg_r.grid_rows    <= pmc_pkg::ResetRows;
      cfg_r.motion_shift <= pmc_pkg::ResetShift;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.addr)
        pmc_pkg::REG_GRID_COLUMNS: cfg_r.grid_columns <= cfg_ch.data;
        pmc_pkg::REG_GRID_ROWS:    cfg_r.grid_rows    <= cfg_ch.data;
        pmc_pkg::REG_MOTION_SHIFT: cfg_r.motion_shift <= cfg_ch.data[pmc_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  pmc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .ctrl_status (in_ch.ctrl_status),
    .rx_byte     (in_ch.rx_byte),
    .push        (push),
    .push_pkt    (push_pkt)
  );

  pmc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head_pkt (head_pkt),
    .status   (q_status)
  );

  pmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .head_pkt  (head_pkt),
    .pop       (pop),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.cursor_x    = res.cursor_x;
  assign out_ch.cursor_y    = res.cursor_y;
  assign out_ch.button_bits = res.button_bits;
  assign out_ch.moved       = res.moved;
  assign out_ch.old_cell    = res.old_cell;
  assign out_ch.new_cell    = res.new_cell;

  a_push_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> in_fire)
    else $error("packet pushed without an input transfer");

  a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> !q_status.empty)
    else $error("queue empty after a push");

  a_still_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.moved |-> out_ch.old_cell == out_ch.new_cell)
    else $error("unmoved cursor reports different cells");

endmodule

// File: test/ps2_mouse_packet_cursor_top_test.sv
module ps2_mouse_packet_cursor_top_test;
  import pmc_pkg::*;

  localparam logic [ByteW-1:0] StatusGate = (8'd1 << StatusFullBit) | (8'd1 << StatusAuxBit);
  localparam logic [ByteW-1:0] StNone     = 8'h00;
  localparam logic [ByteW-1:0] StFullOnly = 8'h01;
  localparam logic [ByteW-1:0] StAuxOnly  = 8'h20;
  localparam logic [ByteW-1:0] StAll      = 8'hFF;
  localparam logic [ByteW-1:0] StNoise    = 8'hDE;

  localparam logic [1:0] PhaseHeader = 2'd0;
  localparam logic [1:0] PhaseDx     = 2'd1;

  localparam int DrainCycles  = 8;
  localparam int RandomPhases = 10;
  localparam int PhaseBytes   = 100;

  typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    cfg_reg_t         reg_sel;
    logic [ByteW-1:0] status;
    logic [ByteW-1:0] data;
    bit               typed;
    result_t          want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;

  // cursor tracker: configuration and packet state
  logic [ByteW-1:0]  grid_cols = ResetColumns;
  logic [ByteW-1:0]  grid_rows = ResetRows;
  logic [ShiftW-1:0] shift_amt = ResetShift;
  logic [1:0]        trk_phase = PhaseHeader;
  logic [ByteW-1:0]  trk_header = '0;
  logic [ByteW-1:0]  trk_dx = '0;
  logic [ByteW-1:0]  trk_x = ResetPosX;
  logic [ByteW-1:0]  trk_y = ResetPosY;

  result_t cursor_expect[$];
  dir_row_t dir_rows[$];

  pmc_in_if  in_ch ();
  pmc_out_if out_ch ();
  pmc_cfg_if cfg_ch ();

  assign out_ch.ready = sink_ready;

  ps2_mouse_packet_cursor_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int scale_motion(input logic [ByteW-1:0] raw, input logic [ShiftW-1:0] sh);
    int mag;
    mag = raw[ByteW-1] ? 256 - int'(raw) : int'(raw);
    mag = mag >> sh;
    return raw[ByteW-1] ? -mag : mag;
  endfunction

  function automatic logic [ByteW-1:0] clamp_to_grid(input int v, input logic [ByteW-1:0] size);
    int top;
    top = (size == 0) ? 0 : int'(size) - 1;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v[ByteW-1:0];
  endfunction

  // advance the tracker by one byte; returns 1 when a packet completes
  function automatic bit advance_cursor(input logic [ByteW-1:0] st, input logic [ByteW-1:0] d,
                                        output result_t r);
    int dx;
    int dy;
    logic [ByteW-1:0] nx;
    logic [ByteW-1:0] ny;
    r = '0;
    if (!st[StatusFullBit] || !st[StatusAuxBit]) return 1'b0;
    if (trk_phase == PhaseHeader) begin
      // drop bytes until a header with the sync bit shows up
      if (!d[HeaderSyncBit]) return 1'b0;
      trk_header = d;
      trk_phase = PhaseDx;
      return 1'b0;
    end
    if (trk_phase == PhaseDx) begin
      trk_dx = d;
      trk_phase = 2'd2;
      return 1'b0;
    end
    trk_phase = PhaseHeader;
    dx = scale_motion(trk_dx, shift_amt);
    dy = scale_motion(d, shift_amt);
    nx = clamp_to_grid(int'(trk_x) + dx, grid_cols);
    ny = clamp_to_grid(int'(trk_y) - dy, grid_rows);
    r.cursor_x = nx;
    r.cursor_y = ny;
    r.button_bits = trk_header[ButtonW-1:0];
    r.moved = (nx != trk_x) || (ny != trk_y);
    r.old_cell = CellW'(int'(trk_y) * int'(grid_cols) + int'(trk_x));
    r.new_cell = CellW'(int'(ny) * int'(grid_cols) + int'(nx));
    trk_x = nx;
    trk_y = ny;
    return 1'b1;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("x=%0d y=%0d buttons=%0d moved=%0d old_cell=%0d new_cell=%0d",
                     r.cursor_x, r.cursor_y, r.button_bits, r.moved, r.old_cell, r.new_cell);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.cursor_x = out_ch.cursor_x;
      seen.cursor_y = out_ch.cursor_y;
      seen.button_bits = out_ch.button_bits;
      seen.moved = out_ch.moved;
      seen.old_cell = out_ch.old_cell;
      seen.new_cell = out_ch.new_cell;
      if (cursor_expect.size() == 0) begin
        note_failure({"unexpected result: ", fmt_result(seen)});
      end else begin
        want = cursor_expect.pop_front();
        if (seen !== want)
          note_failure({"mismatch: expected ", fmt_result(want), " got ", fmt_result(seen)});
      end
    end
  end

  function automatic dir_row_t byte_row(input logic [ByteW-1:0] st, input logic [ByteW-1:0] d);
    dir_row_t row;
    row.kind = ROW_BYTE;
    row.reg_sel = REG_GRID_COLUMNS;
    row.status = st;
    row.data = d;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t checked_row(input logic [ByteW-1:0] st, input logic [ByteW-1:0] d,
                                           input int x, input int y, input int b, input int m,
                                           input int oc, input int nc);
    dir_row_t row;
    row = byte_row(st, d);
    row.typed = 1'b1;
    row.want.cursor_x = ByteW'(x);
    row.want.cursor_y = ByteW'(y);
    row.want.button_bits = ButtonW'(b);
    row.want.moved = m[0];
    row.want.old_cell = CellW'(oc);
    row.want.new_cell = CellW'(nc);
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input cfg_reg_t sel, input logic [ByteW-1:0] v);
    dir_row_t row;
    row = byte_row(StNone, v);
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    return row;
  endfunction

  function automatic logic [ByteW-1:0] good_status();
    return ByteW'($urandom) | StatusGate;
  endfunction

  function automatic logic [ByteW-1:0] bad_status();
    logic [ByteW-1:0] s;
    s = ByteW'($urandom);
    case ($urandom_range(2))
      0: begin
        s[StatusFullBit] = 1'b0;
      end
      1: begin
        s[StatusAuxBit] = 1'b0;
      end
      default: begin
        s[StatusFullBit] = 1'b0;
        s[StatusAuxBit] = 1'b0;
      end
    endcase
    return s;
  endfunction

  // mostly small moves so the cursor wanders instead of pinning to an edge
  function automatic logic [ByteW-1:0] rand_motion();
    if ($urandom_range(1) == 0) return ByteW'($urandom);
    return ByteW'($urandom_range(8)) - 8'd4;
  endfunction

  function automatic logic [ByteW-1:0] pick_extent();
    case ($urandom_range(3))
      0: return 8'd1;
      1: return 8'd255;
      default: return ByteW'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic set_idle(input int stage);
    case (stage)
      0: begin
        send_idle_pct = 20;
        recv_idle_pct = 86;
      end
      1: begin
        send_idle_pct = 86;
        recv_idle_pct = 20;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // valid is left high after the transfer so back-to-back bytes need no extra edge
  task automatic send_byte(input logic [ByteW-1:0] st, input logic [ByteW-1:0] d,
                           input bit typed, input result_t want);
    result_t r;
    bit got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ctrl_status <= st;
    in_ch.rx_byte <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = advance_cursor(st, d, r);
    if (got) cursor_expect.push_back(typed ? want : r);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(9) == 0) send_byte(bad_status(), ByteW'($urandom), 1'b0, '0);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (cursor_expect.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [ByteW-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr <= sel;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (sel)
      REG_GRID_COLUMNS: grid_cols = v;
      REG_GRID_ROWS:    grid_rows = v;
      REG_MOTION_SHIFT: shift_amt = v[ShiftW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_random(input int n_bytes);
    int sent;
    int pick;
    logic [ByteW-1:0] hdr;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        hdr = ByteW'($urandom);
        hdr[HeaderSyncBit] = 1'b1;
        send_byte(good_status(), hdr, 1'b0, '0);
        maybe_noise();
        send_byte(good_status(), rand_motion(), 1'b0, '0);
        maybe_noise();
        send_byte(good_status(), rand_motion(), 1'b0, '0);
        sent += 3;
      end else if (pick < 90) begin
        send_byte(bad_status(), ByteW'($urandom), 1'b0, '0);
      end else begin
        // stray byte: knocks the packet framing out of step
        send_byte(good_status(), ByteW'($urandom), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("ps2_mouse_packet_cursor_top_test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.ctrl_status = '0;
    in_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_GRID_COLUMNS;
    cfg_ch.data = '0;

    dir_rows = '{
      // status gate: each missing bit drops the byte
      byte_row(StNone, 8'h08),
      byte_row(StFullOnly, 8'h08),
      byte_row(StAuxOnly, 8'h08),
      // no sync bit at header position; the next byte with it starts a packet
      byte_row(StatusGate, 8'h00),
      byte_row(StatusGate, 8'h0F),
      byte_row(StatusGate, 8'h00),
      checked_row(StatusGate, 8'h00, 40, 12, 7, 0, 1000, 1000),
      byte_row(StAll, 8'hFF),
      byte_row(StAll, 8'h7F),
      checked_row(StAll, 8'h80, 55, 24, 7, 1, 1000, 1975),
      cfg_row(REG_MOTION_SHIFT, 8'd0),
      cfg_row(REG_GRID_COLUMNS, 8'd255),
      cfg_row(REG_GRID_ROWS, 8'd255),
      byte_row(StatusGate, 8'h0D),
      byte_row(StatusGate, 8'h7F),
      byte_row(StNoise, 8'h55),
      byte_row(StatusGate, 8'h80),
      byte_row(StatusGate, 8'h08),
      byte_row(StatusGate, 8'h7F),
      checked_row(StatusGate, 8'h80, 254, 254, 0, 1, 38942, 65024),
      // shrink the grid under the cursor
      cfg_row(REG_GRID_COLUMNS, 8'd10),
      cfg_row(REG_GRID_ROWS, 8'd5),
      cfg_row(REG_MOTION_SHIFT, 8'd7),
      byte_row(StatusGate, 8'h0B),
      byte_row(StatusGate, 8'h01),
      checked_row(StatusGate, 8'hFF, 9, 4, 3, 1, 2794, 49),
      // zero columns clamps the column to zero and gives a row stride of zero
      cfg_row(REG_GRID_COLUMNS, 8'd0),
      cfg_row(REG_GRID_ROWS, 8'd1),
      cfg_row(REG_MOTION_SHIFT, 8'd0),
      byte_row(StatusGate, 8'h08),
      byte_row(StatusGate, 8'h7F),
      checked_row(StatusGate, 8'h7F, 0, 0, 0, 1, 9, 0),
      // small negative motion truncates to zero, not minus one
      cfg_row(REG_GRID_COLUMNS, ResetColumns),
      cfg_row(REG_GRID_ROWS, ResetRows),
      cfg_row(REG_MOTION_SHIFT, 8'(ResetShift)),
      byte_row(StatusGate, 8'h0C),
      byte_row(StatusGate, 8'hF9),
      checked_row(StatusGate, 8'h07, 0, 0, 4, 0, 0, 0)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].data);
      end else begin
        send_byte(dir_rows[i].status, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < RandomPhases; p++) begin
      set_idle(p < 4 ? 0 : (p < 7 ? 1 : 2));
      settle();
      write_reg(REG_GRID_COLUMNS, pick_extent());
      write_reg(REG_GRID_ROWS, pick_extent());
      write_reg(REG_MOTION_SHIFT, ByteW'($urandom_range(7)));
      run_random(PhaseBytes);
    end

    settle();
    if (fail_count == 0 && cursor_expect.size() == 0) begin
      $display("ps2_mouse_packet_cursor_top_test passed");
    end else begin
      $display("ps2_mouse_packet_cursor_top_test failed");
    end
    $finish;
  end

endmodule
